@@ hw/rtl/imheap_pkg.sv @@
`default_nettype none
package imheap_pkg;

	localparam int NUM_IDS_DEF   = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int ID_W          = 6;
	localparam int KEY_IN_W      = 32;
	localparam int CNT_OUT_W     = 7;

	typedef enum logic [1:0] {
		MODE_INSERT  = 2'd0,
		MODE_REPLACE = 2'd1,
		MODE_REMOVE  = 2'd2,
		MODE_QUERY   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_DUP     = 2'd1,
		STS_UNSCHED = 2'd2
	} status_t;

	typedef struct packed {
		logic    clr_wr;
		logic    latch;
		logic    lookup;
		logic    ins_setup;
		logic    rep_setup;
		logic    rem_setup;
		logic    rem_last;
		logic    up_read;
		logic    up_move;
		logic    dn_read_l;
		logic    dn_read_r;
		logic    dn_move;
		logic    finish;
		logic    out_load;
		status_t code;
		logic    id_sched;
	} imh_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic in_range;
		logic sched;
		logic full;
		logic is_last;
		logic at_root;
		logic up_less;
		logic has_left;
		logic dn_swap;
		logic out_busy;
	} imh_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/imheap_ram.sv @@
`default_nettype none
module imheap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wa,
	input  wire logic [WIDTH-1:0]         wd,
	input  wire logic [$clog2(DEPTH)-1:0] ra,
	output logic      [WIDTH-1:0]         rd
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule
`default_nettype wire

@@ hw/rtl/imheap_ctrl.sv @@
`default_nettype none
module imheap_ctrl
	import imheap_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic [1:0] mode,
	input  imh_sts_t      sts,
	output imh_cmd_t      cmd
);
	typedef enum logic [10:0] {
		S_CLR    = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_LOOK   = 11'b00000000100,
		S_DEC    = 11'b00000001000,
		S_UP_RD  = 11'b00000010000,
		S_UP_CMP = 11'b00000100000,
		S_DN_RD  = 11'b00001000000,
		S_DN_R   = 11'b00010000000,
		S_DN_CMP = 11'b00100000000,
		S_FIN    = 11'b01000000000,
		S_OUT    = 11'b10000000000
	} state_t;

	state_t  state_q, state_d;
	mode_t   mode_q;
	status_t code_q, code_d;
	logic    idsch_q, idsch_d;
	logic    moved_q, moved_d;
	logic    second_q, second_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.code     = code_q;
		cmd.id_sched = idsch_q;
		state_d      = state_q;
		code_d       = code_q;
		idsch_d      = idsch_q;
		moved_d      = moved_q;
		second_d     = second_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = S_DEC;
			end
			S_DEC: begin
				code_d   = STS_OK;
				idsch_d  = sts.sched;
				moved_d  = 1'b0;
				second_d = 1'b0;
				state_d  = S_OUT;
				unique case (mode_q)
					MODE_INSERT: begin
						if (!sts.in_range) begin
							code_d = STS_UNSCHED;
						end else if (sts.sched) begin
							code_d = STS_DUP;
						end else if (!sts.full) begin
							cmd.ins_setup = 1'b1;
							idsch_d       = 1'b1;
							state_d       = S_UP_RD;
						end
					end
					MODE_REPLACE: begin
						if (!sts.sched) begin
							code_d = STS_UNSCHED;
						end else begin
							cmd.rep_setup = 1'b1;
							second_d      = 1'b1;
							state_d       = S_UP_RD;
						end
					end
					MODE_REMOVE: begin
						idsch_d = 1'b0;
						if (!sts.sched) begin
							code_d = STS_UNSCHED;
						end else if (sts.is_last) begin
							cmd.rem_last = 1'b1;
						end else begin
							cmd.rem_setup = 1'b1;
							second_d      = 1'b1;
							state_d       = S_DN_RD;
						end
					end
					MODE_QUERY: begin
					end
					default: begin
					end
				endcase
			end
			S_UP_RD: begin
				if (sts.at_root) begin
					state_d  = (second_q && !moved_q) ? S_DN_RD : S_FIN;
					second_d = 1'b0;
				end else begin
					cmd.up_read = 1'b1;
					state_d     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_less) begin
					cmd.up_move = 1'b1;
					moved_d     = 1'b1;
					state_d     = S_UP_RD;
				end else begin
					state_d  = (second_q && !moved_q) ? S_DN_RD : S_FIN;
					second_d = 1'b0;
				end
			end
			S_DN_RD: begin
				if (!sts.has_left) begin
					state_d  = (second_q && !moved_q) ? S_UP_RD : S_FIN;
					second_d = 1'b0;
				end else begin
					cmd.dn_read_l = 1'b1;
					state_d       = S_DN_R;
				end
			end
			S_DN_R: begin
				cmd.dn_read_r = 1'b1;
				state_d       = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (sts.dn_swap) begin
					cmd.dn_move = 1'b1;
					moved_d     = 1'b1;
					state_d     = S_DN_RD;
				end else begin
					state_d  = (second_q && !moved_q) ? S_UP_RD : S_FIN;
					second_d = 1'b0;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			mode_q   <= MODE_QUERY;
			code_q   <= STS_OK;
			idsch_q  <= 1'b0;
			moved_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			code_q   <= code_d;
			idsch_q  <= idsch_d;
			moved_q  <= moved_d;
			second_q <= second_d;
			if (cmd.latch) begin
				mode_q <= mode_t'(mode);
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/imheap_dp.sv @@
`default_nettype none
module imheap_dp
	import imheap_pkg::*;
#(
	parameter int NUM_IDS   = NUM_IDS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  imh_cmd_t                   cmd,
	output imh_sts_t                   sts,
	input  wire logic [ID_W-1:0]       event_id,
	input  wire logic [KEY_IN_W-1:0]   sort_key,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 status,
	output logic [ID_W-1:0]            top_id,
	output logic [KEY_IN_W-1:0]        top_key,
	output logic                       queue_empty,
	output logic [CNT_OUT_W-1:0]       entry_count,
	output logic                       id_scheduled
);
	localparam int IW  = $clog2(NUM_IDS);
	localparam int KW  = KEY_WIDTH;
	localparam int CW  = $clog2(NUM_IDS + 1);
	localparam int HW  = IW + KW;
	localparam int PW  = IW + 1;
	localparam int LW  = IW + 2;
	localparam int XW  = (IW > ID_W) ? IW : ID_W;
	localparam int KX  = (KW > KEY_IN_W) ? KW : KEY_IN_W;
	localparam int OX  = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] hole_q, id_q, clr_q, e_id_q, root_id_q;
	logic [KW-1:0] key_q, e_key_q, root_key_q;
	logic          inr_q;
	logic [HW-1:0] l_q;

	logic [XW-1:0] id_x;
	logic [KX-1:0] key_x;
	assign id_x  = XW'(event_id);
	assign key_x = KX'(sort_key);

	logic          h_we, p_we;
	logic [IW-1:0] h_wa, h_ra, p_wa;
	logic [HW-1:0] h_wd, h_rd;
	logic [PW-1:0] p_wd, p_rd;

	imheap_ram #(.WIDTH(HW), .DEPTH(NUM_IDS)) u_heap (
		.clk(clk), .we(h_we), .wa(h_wa), .wd(h_wd), .ra(h_ra), .rd(h_rd)
	);

	imheap_ram #(.WIDTH(PW), .DEPTH(NUM_IDS)) u_pos (
		.clk(clk), .we(p_we), .wa(p_wa), .wd(p_wd), .ra(id_q), .rd(p_rd)
	);

	logic [CW-1:0] cnt_m1;
	logic [IW-1:0] hole_m1, parent;
	logic [LW-1:0] l_idx, r_idx, cnt_l;
	logic          r_ok, take_l;
	logic [HW-1:0] m_ent;
	logic [LW-1:0] m_idx;
	logic [IW-1:0] slot;

	assign cnt_m1  = cnt_q - CW'(1);
	assign hole_m1 = hole_q - IW'(1);
	assign parent  = hole_m1 >> 1;
	assign l_idx   = {1'b0, hole_q, 1'b1};
	assign r_idx   = l_idx + LW'(1);
	assign cnt_l   = LW'(cnt_q);
	assign r_ok    = r_idx < cnt_l;
	assign take_l  = !r_ok || (l_q[KW-1:0] < h_rd[KW-1:0]);
	assign m_ent   = take_l ? l_q : h_rd;
	assign m_idx   = take_l ? l_idx : r_idx;
	assign slot    = p_rd[IW-1:0];

	always_comb begin
		h_ra = '0;
		priority if (cmd.lookup) begin
			h_ra = cnt_m1[IW-1:0];
		end else if (cmd.up_read) begin
			h_ra = parent;
		end else if (cmd.dn_read_l) begin
			h_ra = l_idx[IW-1:0];
		end else if (cmd.dn_read_r) begin
			h_ra = r_idx[IW-1:0];
		end

		h_we = cmd.up_move || cmd.dn_move || cmd.finish;
		h_wa = hole_q;
		priority if (cmd.up_move) begin
			h_wd = h_rd;
		end else if (cmd.dn_move) begin
			h_wd = m_ent;
		end else begin
			h_wd = {e_id_q, e_key_q};
		end

		p_we = cmd.clr_wr || cmd.rem_setup || cmd.rem_last || h_we;
		p_wd = {1'b1, hole_q};
		priority if (cmd.clr_wr) begin
			p_wa = clr_q;
			p_wd = '0;
		end else if (cmd.rem_setup || cmd.rem_last) begin
			p_wa = id_q;
			p_wd = '0;
		end else begin
			p_wa = h_wd[HW-1:KW];
		end
	end

	assign sts.clr_done = (clr_q == IW'(NUM_IDS - 1));
	assign sts.in_range = inr_q;
	assign sts.sched    = inr_q && p_rd[IW];
	assign sts.full     = (cnt_q == CW'(NUM_IDS));
	assign sts.is_last  = (CW'(slot) == cnt_m1);
	assign sts.at_root  = (hole_q == '0);
	assign sts.up_less  = e_key_q < h_rd[KW-1:0];
	assign sts.has_left = l_idx < cnt_l;
	assign sts.dn_swap  = m_ent[KW-1:0] < e_key_q;
	assign sts.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cmd.ins_setup) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.rem_setup || cmd.rem_last) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	logic [XW:0]   root_idx;
	logic [KX-1:0] root_kx;
	logic [OX-1:0] cnt_x;
	assign root_idx = (XW + 1)'(root_id_q);
	assign root_kx  = KX'(root_key_q);
	assign cnt_x    = OX'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q  <= id_x[IW-1:0];
			inr_q <= ((XW + 1)'(id_x) < (XW + 1)'(NUM_IDS));
			key_q <= key_x[KW-1:0];
		end
		if (cmd.ins_setup) begin
			hole_q  <= cnt_q[IW-1:0];
			e_id_q  <= id_q;
			e_key_q <= key_q;
		end
		if (cmd.rep_setup) begin
			hole_q  <= slot;
			e_id_q  <= id_q;
			e_key_q <= key_q;
		end
		if (cmd.rem_setup) begin
			hole_q  <= slot;
			e_id_q  <= h_rd[HW-1:KW];
			e_key_q <= h_rd[KW-1:0];
		end
		if (cmd.up_move) begin
			hole_q <= parent;
		end
		if (cmd.dn_move) begin
			hole_q <= m_idx[IW-1:0];
		end
		if (cmd.dn_read_r) begin
			l_q <= h_rd;
		end
		if (h_we && h_wa == '0) begin
			root_id_q  <= h_wd[HW-1:KW];
			root_key_q <= h_wd[KW-1:0];
		end
		if (cmd.out_load) begin
			status       <= cmd.code;
			queue_empty  <= (cnt_q == '0);
			top_id       <= (cnt_q == '0) ? '0 : root_idx[ID_W-1:0];
			top_key      <= (cnt_q == '0) ? '0 : root_kx[KEY_IN_W-1:0];
			entry_count  <= cnt_x[CNT_OUT_W-1:0];
			id_scheduled <= cmd.id_sched;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/indexed_min_heap_event_queue_top.sv @@
`default_nettype none
// Channel   Signals                                   Direction
// in        in_valid/in_ready: mode,event_id,sort_key  request in
// out       out_valid/out_ready: status,top_id,top_key, result out
//           queue_empty,entry_count,id_scheduled
//
// One request at a time. A query, a refused request or removal of the last slot
// goes from acceptance through lookup and decode straight to the result. Insert, replace
// and remove add the end-of-walk check and the final write, plus a parent read and
// compare per level of sift-up and a left-child read, right-child read and compare per
// level of sift-down on the single-read heap RAM.
// After reset a clearing pass empties the position table;
// in_ready stays low during it.
// A result held by out_ready low stalls only the end of the next request.
module indexed_min_heap_event_queue_top
	import imheap_pkg::*;
#(
	parameter int NUM_IDS   = NUM_IDS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           mode,
	input  wire logic [ID_W-1:0]      event_id,
	input  wire logic [KEY_IN_W-1:0]  sort_key,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                status,
	output logic [ID_W-1:0]           top_id,
	output logic [KEY_IN_W-1:0]       top_key,
	output logic                      queue_empty,
	output logic [CNT_OUT_W-1:0]      entry_count,
	output logic                      id_scheduled
);
	imh_cmd_t cmd;
	imh_sts_t sts;

	imheap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .sts(sts), .cmd(cmd)
	);

	imheap_dp #(.NUM_IDS(NUM_IDS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.event_id(event_id), .sort_key(sort_key),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.top_id(top_id), .top_key(top_key), .queue_empty(queue_empty),
		.entry_count(entry_count), .id_scheduled(id_scheduled)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queue_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_empty |-> (top_id == '0) && (top_key == '0))
		else $error("nonzero top on empty queue");
endmodule
`default_nettype wire
